// ===== rtl/image_handle_pool_core_assert.svh =====
// assertion macros for the image handle pool checker
// each macro expects clk and rst_n in scope
`ifndef IMAGE_HANDLE_POOL_CORE_ASSERT_SVH
`define IMAGE_HANDLE_POOL_CORE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define IHP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define IHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ihp_pkg.sv =====
`default_nettype none

package ihp_pkg;

    // default number of pool slots
    localparam int POOL_DEPTH_DEF = 16;

    // field widths
    localparam int CMD_W    = 2;
    localparam int HANDLE_W = 64;
    localparam int DIM_W    = 16;
    localparam int FMT_W    = 31;
    localparam int LAYOUT_W = 31;
    localparam int USAGE_W  = 32;
    localparam int CAP_W    = 5;
    localparam int COUNT_W  = 5;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // pool commands
    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_ADD     = 2'd2,
        CMD_DRAIN   = 2'd3
    } cmd_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // one slot of the handle store
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [DIM_W-1:0]    img_width;
        logic [DIM_W-1:0]    img_height;
        logic [FMT_W-1:0]    pixel_format;
        logic [LAYOUT_W-1:0] layout;
        logic [USAGE_W-1:0]  usage;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/ihp_ram.sv =====
`default_nettype none

module ihp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/ihp_ctrl.sv =====
`default_nettype none

module ihp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ihp_pkg::dp_status_t   sts,
    output ihp_pkg::ctl_cmd_t     ctl
);

    ihp_pkg::state_t state_reg;
    ihp_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ihp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ihp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ihp_pkg::ST_SCAN;
                end
            end
            ihp_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ihp_pkg::ST_FINISH;
                end
            end
            ihp_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ihp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ihp_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath commands and input stall
    always_comb
    begin
        ctl      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ihp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                ctl.load = in_valid;
            end
            ihp_pkg::ST_SCAN:
            begin
                ctl.scan = 1'b1;
            end
            ihp_pkg::ST_FINISH:
            begin
                ctl.commit = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ihp_datapath.sv =====
`default_nettype none

module ihp_datapath #(
    parameter int POOL_DEPTH = ihp_pkg::POOL_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ihp_pkg::ctl_cmd_t             ctl,
    output ihp_pkg::dp_status_t           sts,
    input  logic [ihp_pkg::CMD_W-1:0]     cmd,
    input  logic [ihp_pkg::HANDLE_W-1:0]  handle,
    input  logic [ihp_pkg::DIM_W-1:0]     img_width,
    input  logic [ihp_pkg::DIM_W-1:0]     img_height,
    input  logic [ihp_pkg::FMT_W-1:0]     pixel_format,
    input  logic [ihp_pkg::LAYOUT_W-1:0]  layout_in,
    input  logic [ihp_pkg::USAGE_W-1:0]   usage_in,
    input  logic                          capacity_we,
    input  logic [ihp_pkg::CAP_W-1:0]     capacity_wdata,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [ihp_pkg::HANDLE_W-1:0]  got_handle,
    output logic [ihp_pkg::LAYOUT_W-1:0]  layout_out,
    output logic [ihp_pkg::USAGE_W-1:0]   usage_out,
    output logic                          destroy_valid,
    output logic [ihp_pkg::HANDLE_W-1:0]  destroy_handle,
    output logic [ihp_pkg::COUNT_W-1:0]   used_count,
    output logic [ihp_pkg::COUNT_W-1:0]   idle_count,
    output logic                          last
);

    localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int MW = (CW > ihp_pkg::CAP_W) ? CW : ihp_pkg::CAP_W;
    localparam int OW = ihp_pkg::COUNT_W;
    localparam int EW = $bits(ihp_pkg::entry_t);
    localparam logic [IW-1:0] LAST_IDX = IW'(POOL_DEPTH - 1);
    localparam logic [MW-1:0] DEPTH_M  = MW'(POOL_DEPTH);

    // slot flags and counters
    logic [POOL_DEPTH-1:0] occ_reg,  occ_next;
    logic [POOL_DEPTH-1:0] busy_reg, busy_next;
    logic [POOL_DEPTH-1:0] nz_reg,   nz_next;
    logic [CW-1:0]         used_reg, used_next;
    logic [CW-1:0]         idle_reg, idle_next;
    logic [ihp_pkg::CAP_W-1:0] capacity_reg;

    // captured item
    ihp_pkg::cmd_t                 cmd_reg;
    logic [ihp_pkg::HANDLE_W-1:0]  handle_reg;
    logic [ihp_pkg::DIM_W-1:0]     width_reg;
    logic [ihp_pkg::DIM_W-1:0]     height_reg;
    logic [ihp_pkg::FMT_W-1:0]     format_reg;
    logic [ihp_pkg::LAYOUT_W-1:0]  layout_reg;
    logic [ihp_pkg::USAGE_W-1:0]   usage_reg;

    // sweep pipeline
    logic [IW-1:0] ptr_reg;
    logic          issue_reg;
    logic [IW-1:0] chk_idx_reg;
    logic          chk_valid_reg;

    // sweep findings
    logic                          hit_found_reg;
    logic [IW-1:0]                 hit_idx_reg;
    ihp_pkg::entry_t               hit_entry_reg;
    logic                          free_found_reg;
    logic [IW-1:0]                 free_idx_reg;
    logic                          idle_found_reg;
    logic [IW-1:0]                 idle_idx_reg;
    logic [ihp_pkg::HANDLE_W-1:0]  idle_handle_reg;
    logic                          drain_any_reg;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic                          ok_reg;
    logic [ihp_pkg::HANDLE_W-1:0]  got_handle_reg;
    logic [ihp_pkg::LAYOUT_W-1:0]  layout_out_reg;
    logic [ihp_pkg::USAGE_W-1:0]   usage_out_reg;
    logic                          destroy_valid_reg;
    logic [ihp_pkg::HANDLE_W-1:0]  destroy_handle_reg;
    logic [OW-1:0]                 used_count_reg;
    logic [OW-1:0]                 idle_count_reg;
    logic                          last_reg;

    // ram signals
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    ihp_pkg::entry_t   ram_wentry;
    logic [EW-1:0]     ram_rword;
    logic              ram_re;
    ihp_pkg::entry_t   rd_entry;

    // combinational sweep terms
    logic is_acq;
    logic is_drain;
    logic out_free;
    logic cur_occ;
    logic cur_busy;
    logic cur_nz;
    logic acq_match;
    logic h_match;
    logic hit_now;
    logic held;
    logic later_held;
    logic hold;
    logic step;
    logic drain_emit;

    // commit terms
    logic [MW-1:0]  cap_ext;
    logic [MW-1:0]  used_ext;
    logic [MW-1:0]  cap_sat;
    logic           pool_full;
    ihp_pkg::entry_t new_entry;

    // result being loaded
    logic                          out_load;
    logic                          r_ok;
    logic [ihp_pkg::HANDLE_W-1:0]  r_got;
    logic [ihp_pkg::LAYOUT_W-1:0]  r_layout;
    logic [ihp_pkg::USAGE_W-1:0]   r_usage;
    logic                          r_dv;
    logic [ihp_pkg::HANDLE_W-1:0]  r_dh;
    logic [OW-1:0]                 r_used;
    logic [OW-1:0]                 r_idle;
    logic                          r_last;

    // slot payload store
    ihp_ram #(
        .WIDTH (EW),
        .DEPTH (POOL_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rword)
    );

    assign rd_entry = ihp_pkg::entry_t'(ram_rword);

    // sweep decode of the slot under check
    assign is_acq   = (cmd_reg == ihp_pkg::CMD_ACQUIRE);
    assign is_drain = (cmd_reg == ihp_pkg::CMD_DRAIN);
    assign out_free = !out_valid_reg || !out_stall;
    assign cur_occ  = occ_reg[chk_idx_reg];
    assign cur_busy = busy_reg[chk_idx_reg];
    assign cur_nz   = nz_reg[chk_idx_reg];

    assign acq_match = cur_occ && !cur_busy && cur_nz
                       && (rd_entry.img_width == width_reg)
                       && (rd_entry.img_height == height_reg)
                       && (rd_entry.pixel_format == format_reg);
    assign h_match   = cur_occ && (rd_entry.handle == handle_reg);
    assign hit_now   = is_acq ? acq_match : h_match;
    assign held      = cur_occ && cur_nz;

    // any held handle beyond the slot under check
    always_comb
    begin
        later_held = 1'b0;
        for (int j = 0; j < POOL_DEPTH; j++)
        begin
            if (occ_reg[j] && nz_reg[j] && (IW'(j) > chk_idx_reg))
            begin
                later_held = 1'b1;
            end
        end
    end

    // a drain pauses at a held slot while a finished item waits downstream
    assign hold       = ctl.scan && chk_valid_reg && is_drain && held && !out_free;
    assign step       = ctl.scan && chk_valid_reg && !hold;
    assign drain_emit = step && is_drain && held;
    assign ram_re     = ctl.scan && issue_reg && !hold;

    assign sts.scan_done = step && (chk_idx_reg == LAST_IDX);
    assign sts.out_free  = out_free;

    // capacity saturates at the pool depth
    assign cap_ext   = MW'(capacity_reg);
    assign used_ext  = MW'(used_reg);
    assign cap_sat   = (cap_ext > DEPTH_M) ? DEPTH_M : cap_ext;
    assign pool_full = (used_ext >= cap_sat);

    always_comb
    begin
        new_entry = '{
            handle:       handle_reg,
            img_width:    width_reg,
            img_height:   height_reg,
            pixel_format: format_reg,
            layout:       layout_reg,
            usage:        usage_reg
        };
    end

    // commit of the command and result selection
    always_comb
    begin
        occ_next   = occ_reg;
        busy_next  = busy_reg;
        nz_next    = nz_reg;
        used_next  = used_reg;
        idle_next  = idle_reg;
        ram_we     = 1'b0;
        ram_waddr  = hit_idx_reg;
        ram_wentry = new_entry;
        out_load   = 1'b0;
        r_ok       = 1'b0;
        r_got      = '0;
        r_layout   = '0;
        r_usage    = '0;
        r_dv       = 1'b0;
        r_dh       = '0;
        r_last     = 1'b1;

        if (drain_emit)
        begin
            out_load = 1'b1;
            r_dv     = 1'b1;
            r_dh     = rd_entry.handle;
            r_last   = !later_held;
        end
        else if (ctl.commit)
        begin
            unique case (cmd_reg)
                ihp_pkg::CMD_ACQUIRE:
                begin
                    out_load = 1'b1;
                    if (hit_found_reg)
                    begin
                        busy_next[hit_idx_reg] = 1'b1;
                        idle_next = idle_reg - CW'(1);
                        r_ok      = 1'b1;
                        r_got     = hit_entry_reg.handle;
                        r_layout  = hit_entry_reg.layout;
                        r_usage   = hit_entry_reg.usage;
                    end
                end
                ihp_pkg::CMD_RELEASE:
                begin
                    out_load = 1'b1;
                    if (hit_found_reg)
                    begin
                        busy_next[hit_idx_reg] = 1'b0;
                        if (busy_reg[hit_idx_reg] && nz_reg[hit_idx_reg])
                        begin
                            idle_next = idle_reg + CW'(1);
                        end
                    end
                    else if (handle_reg != '0)
                    begin
                        r_dv = 1'b1;
                        r_dh = handle_reg;
                    end
                end
                ihp_pkg::CMD_ADD:
                begin
                    out_load = 1'b1;
                    if (hit_found_reg)
                    begin
                        // refresh layout and usage, keep the rest
                        ram_we            = 1'b1;
                        ram_waddr         = hit_idx_reg;
                        ram_wentry        = hit_entry_reg;
                        ram_wentry.layout = layout_reg;
                        ram_wentry.usage  = usage_reg;
                        busy_next[hit_idx_reg] = 1'b1;
                        if (!busy_reg[hit_idx_reg] && nz_reg[hit_idx_reg])
                        begin
                            idle_next = idle_reg - CW'(1);
                        end
                        r_ok = 1'b1;
                    end
                    else if (pool_full && idle_found_reg)
                    begin
                        // evict the first idle slot and reuse it
                        ram_we    = 1'b1;
                        ram_waddr = idle_idx_reg;
                        occ_next[idle_idx_reg]  = 1'b1;
                        busy_next[idle_idx_reg] = 1'b1;
                        nz_next[idle_idx_reg]   = (handle_reg != '0);
                        if (nz_reg[idle_idx_reg])
                        begin
                            idle_next = idle_reg - CW'(1);
                            r_dv      = 1'b1;
                            r_dh      = idle_handle_reg;
                        end
                        r_ok = 1'b1;
                    end
                    else if (!pool_full && free_found_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = free_idx_reg;
                        occ_next[free_idx_reg]  = 1'b1;
                        busy_next[free_idx_reg] = 1'b1;
                        nz_next[free_idx_reg]   = (handle_reg != '0);
                        used_next = used_reg + CW'(1);
                        r_ok      = 1'b1;
                    end
                end
                ihp_pkg::CMD_DRAIN:
                begin
                    occ_next  = '0;
                    busy_next = '0;
                    used_next = '0;
                    idle_next = '0;
                    out_load  = !drain_any_reg;
                end
                default:
                begin
                    out_load = 1'b0;
                end
            endcase
        end

        // drain items report zero counts
        if (drain_emit)
        begin
            r_used = '0;
            r_idle = '0;
        end
        else
        begin
            r_used = OW'(used_next);
            r_idle = OW'(idle_next);
        end
    end

    // result valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg        <= '0;
            busy_reg       <= '0;
            nz_reg         <= '0;
            used_reg       <= '0;
            idle_reg       <= '0;
            capacity_reg   <= ihp_pkg::CAP_RESET;
            ptr_reg        <= '0;
            issue_reg      <= 1'b0;
            chk_valid_reg  <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            idle_found_reg <= 1'b0;
            drain_any_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            busy_reg      <= busy_next;
            nz_reg        <= nz_next;
            used_reg      <= used_next;
            idle_reg      <= idle_next;
            out_valid_reg <= out_valid_next;
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
            if (ctl.load)
            begin
                ptr_reg        <= '0;
                issue_reg      <= 1'b1;
                chk_valid_reg  <= 1'b0;
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
                idle_found_reg <= 1'b0;
                drain_any_reg  <= 1'b0;
            end
            else if (ctl.scan && !hold)
            begin
                // sweep address and check stage
                chk_valid_reg <= issue_reg;
                if (issue_reg)
                begin
                    if (ptr_reg == LAST_IDX)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + IW'(1);
                    end
                end
                // first hits in slot order
                if (step)
                begin
                    if (hit_now)
                    begin
                        hit_found_reg <= 1'b1;
                    end
                    if (!cur_occ)
                    begin
                        free_found_reg <= 1'b1;
                    end
                    if (cur_occ && !cur_busy)
                    begin
                        idle_found_reg <= 1'b1;
                    end
                    if (drain_emit)
                    begin
                        drain_any_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // captured item, sweep indexes and result payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= ihp_pkg::cmd_t'(cmd);
            handle_reg <= handle;
            width_reg  <= img_width;
            height_reg <= img_height;
            format_reg <= pixel_format;
            layout_reg <= layout_in;
            usage_reg  <= usage_in;
        end
        if (ctl.scan && !hold && issue_reg)
        begin
            chk_idx_reg <= ptr_reg;
        end
        if (step)
        begin
            if (hit_now && !hit_found_reg)
            begin
                hit_idx_reg   <= chk_idx_reg;
                hit_entry_reg <= rd_entry;
            end
            if (!cur_occ && !free_found_reg)
            begin
                free_idx_reg <= chk_idx_reg;
            end
            if (cur_occ && !cur_busy && !idle_found_reg)
            begin
                idle_idx_reg    <= chk_idx_reg;
                idle_handle_reg <= rd_entry.handle;
            end
        end
        if (out_load)
        begin
            ok_reg             <= r_ok;
            got_handle_reg     <= r_got;
            layout_out_reg     <= r_layout;
            usage_out_reg      <= r_usage;
            destroy_valid_reg  <= r_dv;
            destroy_handle_reg <= r_dh;
            used_count_reg     <= r_used;
            idle_count_reg     <= r_idle;
            last_reg           <= r_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign got_handle     = got_handle_reg;
    assign layout_out     = layout_out_reg;
    assign usage_out      = usage_out_reg;
    assign destroy_valid  = destroy_valid_reg;
    assign destroy_handle = destroy_handle_reg;
    assign used_count     = used_count_reg;
    assign idle_count     = idle_count_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

// ===== rtl/image_handle_pool_core.sv =====
// channel   direction  handshake                 payload
// input     in         in_valid / in_stall       cmd, handle, img_width, img_height,
//                                                pixel_format, layout_in, usage_in
// result    out        out_valid / out_stall     ok, got_handle, layout_out, usage_out,
//                                                destroy_valid, destroy_handle,
//                                                used_count, idle_count, last
// config    in         capacity_we               capacity_wdata
//
// every item is taken in ST_IDLE, swept through the slot store's single registered
// read port in ST_SCAN, and committed in ST_FINISH.
// a drain sends one result per held handle during the sweep and pauses the
// sweep while a finished result is stalled; the commit also waits for room.
// reset clears slot flags and counts and sets capacity to 16; the slot store keeps its data.
`default_nettype none

module image_handle_pool_core #(
    parameter int POOL_DEPTH = ihp_pkg::POOL_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ihp_pkg::CMD_W-1:0]     cmd,
    input  logic [ihp_pkg::HANDLE_W-1:0]  handle,
    input  logic [ihp_pkg::DIM_W-1:0]     img_width,
    input  logic [ihp_pkg::DIM_W-1:0]     img_height,
    input  logic [ihp_pkg::FMT_W-1:0]     pixel_format,
    input  logic [ihp_pkg::LAYOUT_W-1:0]  layout_in,
    input  logic [ihp_pkg::USAGE_W-1:0]   usage_in,
    input  logic                          capacity_we,
    input  logic [ihp_pkg::CAP_W-1:0]     capacity_wdata,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          ok,
    output logic [ihp_pkg::HANDLE_W-1:0]  got_handle,
    output logic [ihp_pkg::LAYOUT_W-1:0]  layout_out,
    output logic [ihp_pkg::USAGE_W-1:0]   usage_out,
    output logic                          destroy_valid,
    output logic [ihp_pkg::HANDLE_W-1:0]  destroy_handle,
    output logic [ihp_pkg::COUNT_W-1:0]   used_count,
    output logic [ihp_pkg::COUNT_W-1:0]   idle_count,
    output logic                          last
);

    ihp_pkg::ctl_cmd_t   ctl;
    ihp_pkg::dp_status_t sts;

    // command sequencing
    ihp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    // slot flags, store sweep and result register
    ihp_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .cmd            (cmd),
        .handle         (handle),
        .img_width      (img_width),
        .img_height     (img_height),
        .pixel_format   (pixel_format),
        .layout_in      (layout_in),
        .usage_in       (usage_in),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ok             (ok),
        .got_handle     (got_handle),
        .layout_out     (layout_out),
        .usage_out      (usage_out),
        .destroy_valid  (destroy_valid),
        .destroy_handle (destroy_handle),
        .used_count     (used_count),
        .idle_count     (idle_count),
        .last           (last)
    );

endmodule

`default_nettype wire

// ===== rtl/ihp_checker.sv =====
`default_nettype none
`include "image_handle_pool_core_assert.svh"

module ihp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          ok,
    input logic [ihp_pkg::HANDLE_W-1:0]  got_handle,
    input logic                          destroy_valid,
    input logic [ihp_pkg::HANDLE_W-1:0]  destroy_handle,
    input logic                          last
);

    // one item at a time: taking an item closes the input
    `IHP_ASSERT_NEXT(a_accept_closes, in_valid && !in_stall, in_stall, "item taken while busy")

    // only a drain sends more than one result, each naming a handle
    `IHP_ASSERT_SAME(a_partial_is_destroy, out_valid && !last, destroy_valid, "partial without destroy")

    // a returned handle always comes with ok
    `IHP_ASSERT_SAME(a_got_needs_ok, out_valid && (got_handle != '0), ok, "handle without ok")

    // destroy handle is clear when nothing is destroyed
    `IHP_ASSERT_SAME(a_destroy_clean, out_valid && !destroy_valid, destroy_handle == '0, "stray destroy handle")

    // stalled result holds
    `IHP_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(destroy_handle) && $stable(last), "stalled result changed")

endmodule

bind image_handle_pool_core ihp_checker u_ihp_checker (.*);

`default_nettype wire
